/* rtl/assert_macros.svh */
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion violated");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion violated");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/ppjs_pkg.sv */
// shared types and constants of the periodic job scheduler
`timescale 1ns / 1ps
package ppjs_pkg;

   localparam int JOB_SLOTS_DEF   = 16;
   localparam int PERIOD_BITS_DEF = 16;

   // operation codes
   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_ADD        = 3'd1;
   localparam logic [2:0] OP_DELETE     = 3'd2;
   localparam logic [2:0] OP_SET_TIMING = 3'd3;
   localparam logic [2:0] OP_SET_RUNS   = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_USED      = 2'd3;

   localparam logic [15:0] RUNS_FOREVER = 16'hFFFF;
   localparam logic [7:0]  NO_PRIORITY  = 8'd255;

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_SELECT,
      S_EMIT
   } sched_state_type;

   typedef struct packed {
      logic valid;
      logic ready;
      logic issue;
   } slot_flags_type;

   typedef struct packed {
      logic ready;
      logic issue;
      logic take;
   } slot_verdict_type;

endpackage

/* rtl/ppjs_if.sv */
// request and response channel interfaces of the scheduler
`timescale 1ns / 1ps
interface ppjs_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         operation;
   logic [3:0]         job_slot;
   logic [6:0]         job_priority;
   logic [15:0]        job_period;
   logic signed [15:0] run_count;

   modport source (output valid, operation, job_slot, job_priority, job_period, run_count,
                   input ready);
   modport sink (input valid, operation, job_slot, job_priority, job_period, run_count,
                 output ready);
endinterface

interface ppjs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [3:0] issued_slot;
   logic       ran;
   logic       last;

   modport source (output valid, status, issued_slot, ran, last, input ready);
   modport sink (input valid, status, issued_slot, ran, last, output ready);
endinterface

/* rtl/ppjs_ram.sv */
// simple dual-port slot memory with registered read data
`timescale 1ns / 1ps
module ppjs_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ppjs_slot_unit.sv */
// shared per-slot unit: countdown update, issue decision and priority compare
`timescale 1ns / 1ps
module ppjs_slot_unit import ppjs_pkg::*; #(
   parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
   input  slot_flags_type          flags,
   input  logic [6:0]              prio,
   input  logic [PERIOD_BITS-1:0]  period,
   input  logic [PERIOD_BITS-1:0]  countdown,
   input  logic [15:0]             runs,
   input  logic [7:0]              best,
   output slot_verdict_type        verdict,
   output logic [PERIOD_BITS-1:0]  countdown_new,
   output logic [15:0]             runs_new
);

   logic                   rdy;
   logic                   iss;
   logic [PERIOD_BITS-1:0] cd;
   logic [15:0]            rn;

   always_comb begin
      rdy = flags.ready;
      iss = 1'b0;
      rn  = runs;
      // running countdowns tick down, never below zero
      cd = (flags.ready && countdown != '0) ? countdown - PERIOD_BITS'(1) : countdown;
      // newly eligible job arms with a full period
      if (flags.valid && runs != '0 && !flags.ready) begin
         rdy = 1'b1;
         cd  = period;
      end
      if (rdy && cd == '0) begin
         if (runs == '0) begin
            rdy = 1'b0;
         end else begin
            iss = 1'b1;
            cd  = period;
            // negative count runs forever
            if (!runs[15]) begin
               rn = runs - 16'd1;
               if (rn == '0) begin
                  rdy = 1'b0;
               end
            end
         end
      end
      verdict.ready = rdy;
      verdict.issue = iss;
      verdict.take  = flags.issue && ({1'b0, prio} < best);
      countdown_new = cd;
      runs_new      = rn;
   end

endmodule

/* rtl/periodic_priority_job_scheduler.sv */
// top level of the periodic fixed-priority job scheduler
// usage:
//  - req_chan carries one operation per transaction: tick, add, delete, set period and
//    priority, or set run count, addressed by slot number
//  - rsp_chan returns one transaction per issued job on a tick, else one status
//    transaction; last marks the final transaction of each request
//  - slot fields live in four small memories read one slot per cycle by a single
//    shared update/compare unit under a four-state sequencer
// request sequence:
//  - add, delete, set, empty tick: result held in the pending registers on acceptance,
//    then moved to the output register once that register is free
//  - tick: one update sweep over all slots, then one selection sweep over all slots and
//    one emit step per issued job (a single sweep and emit when nothing is due); the
//    memory read port and the shared unit set the length of each sweep
//  - req_chan.ready is high only while the sequencer is idle
// reset clears all valid, ready and issue bits at once; the slot memories need
// no clearing since a slot's data is used only after add has written it
// a stalled receiver holds the output register; the sequencer waits in its emit
// state, and the next request can be taken while the final result still waits
`include "assert_macros.svh"
`timescale 1ns / 1ps
module periodic_priority_job_scheduler import ppjs_pkg::*; #(
   parameter int JOB_SLOTS   = JOB_SLOTS_DEF,
   parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   ppjs_req_if.sink   req_chan,
   ppjs_rsp_if.source rsp_chan
);

   localparam int SLOT_BITS = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
   localparam int CNT_BITS  = $clog2(JOB_SLOTS + 1);
   localparam logic [CNT_BITS-1:0] SCAN_END = CNT_BITS'(JOB_SLOTS);

   // sequencer and per-slot flags
   sched_state_type        state_ff, state_in;
   logic [JOB_SLOTS-1:0]   valid_ff, valid_in;
   logic [JOB_SLOTS-1:0]   ready_ff, ready_in;
   logic [JOB_SLOTS-1:0]   issue_ff, issue_in;
   logic [CNT_BITS-1:0]    scan_ff, scan_in;
   logic                   data_valid_ff, data_valid_in;
   logic [SLOT_BITS-1:0]   data_idx_ff, data_idx_in;
   logic [7:0]             best_ff, best_in;
   logic [SLOT_BITS-1:0]   pick_ff, pick_in;

   // pending result and output register
   logic [1:0] pend_status_ff, pend_status_in;
   logic [3:0] pend_slot_ff, pend_slot_in;
   logic       pend_ran_ff, pend_ran_in;
   logic       pend_last_ff, pend_last_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [3:0] rsp_slot_ff, rsp_slot_in;
   logic       rsp_ran_ff, rsp_ran_in;
   logic       rsp_last_ff, rsp_last_in;

   // memory ports
   logic [SLOT_BITS-1:0]   ram_rd_addr, ram_wr_addr;
   logic                   prio_we, period_we, runs_we, cd_we;
   logic [6:0]             prio_wd, prio_rd;
   logic [PERIOD_BITS-1:0] period_wd, period_rd;
   logic [15:0]            runs_wd, runs_rd;
   logic [PERIOD_BITS-1:0] cd_wd, cd_rd;

   // shared unit
   slot_flags_type         unit_flags;
   slot_verdict_type       verdict;
   logic [PERIOD_BITS-1:0] cd_new;
   logic [15:0]            runs_new;

   // request decode
   logic [SLOT_BITS-1:0]   slot_addr;
   logic                   in_range, slot_used, table_empty;
   logic [15:0]            runs_norm;
   logic [PERIOD_BITS-1:0] period_norm;
   logic                   read_go, pass_done, rsp_free;
   logic [JOB_SLOTS-1:0]   pick_mask, issue_left;

   assign slot_addr   = SLOT_BITS'(req_chan.job_slot);
   assign in_range    = 8'(req_chan.job_slot) < 8'(JOB_SLOTS);
   assign slot_used   = in_range && valid_ff[slot_addr];
   assign table_empty = ~|valid_ff;
   // any negative count means run forever
   assign runs_norm   = req_chan.run_count[15] ? RUNS_FOREVER : req_chan.run_count;
   assign period_norm = PERIOD_BITS'(req_chan.job_period);

   // one slot read per cycle during a sweep, data back in the following cycle
   assign read_go     = (state_ff == S_UPDATE || state_ff == S_SELECT) && (scan_ff < SCAN_END);
   assign ram_rd_addr = scan_ff[SLOT_BITS-1:0];
   assign pass_done   = (scan_ff == SCAN_END) && !data_valid_ff;
   assign pick_mask   = JOB_SLOTS'(1) << pick_ff;
   assign issue_left  = issue_ff & ~pick_mask;
   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;

   assign unit_flags.valid = valid_ff[data_idx_ff];
   assign unit_flags.ready = ready_ff[data_idx_ff];
   assign unit_flags.issue = issue_ff[data_idx_ff];

   ppjs_ram #(.DEPTH(JOB_SLOTS), .WIDTH(7)) u_prio_ram (
      .clock(clock), .wr_en(prio_we), .wr_addr(ram_wr_addr), .wr_data(prio_wd),
      .rd_addr(ram_rd_addr), .rd_data(prio_rd)
   );

   ppjs_ram #(.DEPTH(JOB_SLOTS), .WIDTH(PERIOD_BITS)) u_period_ram (
      .clock(clock), .wr_en(period_we), .wr_addr(ram_wr_addr), .wr_data(period_wd),
      .rd_addr(ram_rd_addr), .rd_data(period_rd)
   );

   ppjs_ram #(.DEPTH(JOB_SLOTS), .WIDTH(16)) u_runs_ram (
      .clock(clock), .wr_en(runs_we), .wr_addr(ram_wr_addr), .wr_data(runs_wd),
      .rd_addr(ram_rd_addr), .rd_data(runs_rd)
   );

   ppjs_ram #(.DEPTH(JOB_SLOTS), .WIDTH(PERIOD_BITS)) u_cd_ram (
      .clock(clock), .wr_en(cd_we), .wr_addr(ram_wr_addr), .wr_data(cd_wd),
      .rd_addr(ram_rd_addr), .rd_data(cd_rd)
   );

   ppjs_slot_unit #(.PERIOD_BITS(PERIOD_BITS)) u_unit (
      .flags(unit_flags),
      .prio(prio_rd),
      .period(period_rd),
      .countdown(cd_rd),
      .runs(runs_rd),
      .best(best_ff),
      .verdict(verdict),
      .countdown_new(cd_new),
      .runs_new(runs_new)
   );

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.issued_slot = rsp_slot_ff;
   assign rsp_chan.ran         = rsp_ran_ff;
   assign rsp_chan.last        = rsp_last_ff;

   // next state and datapath control
   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      ready_in       = ready_ff;
      issue_in       = issue_ff;
      best_in        = best_ff;
      pick_in        = pick_ff;
      data_valid_in  = read_go;
      data_idx_in    = ram_rd_addr;
      scan_in        = read_go ? scan_ff + CNT_BITS'(1) : scan_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      pend_ran_in    = pend_ran_ff;
      pend_last_in   = pend_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_ran_in     = rsp_ran_ff;
      rsp_last_in    = rsp_last_ff;
      ram_wr_addr    = slot_addr;
      prio_we        = 1'b0;
      period_we      = 1'b0;
      runs_we        = 1'b0;
      cd_we          = 1'b0;
      prio_wd        = req_chan.job_priority;
      period_wd      = period_norm;
      runs_wd        = runs_norm;
      cd_wd          = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               pend_status_in = STATUS_OK;
               pend_slot_in   = 4'd0;
               pend_ran_in    = 1'b0;
               pend_last_in   = 1'b1;
               state_in       = S_EMIT;
               case (req_chan.operation)
                  OP_TICK: begin
                     if (table_empty) begin
                        pend_status_in = STATUS_EMPTY;
                     end else begin
                        state_in = S_UPDATE;
                        scan_in  = '0;
                     end
                  end
                  OP_ADD: begin
                     if (!in_range) begin
                        pend_status_in = STATUS_NOT_FOUND;
                     end else if (slot_used) begin
                        pend_status_in = STATUS_USED;
                     end else begin
                        prio_we              = 1'b1;
                        period_we            = 1'b1;
                        runs_we              = 1'b1;
                        cd_we                = 1'b1;
                        valid_in[slot_addr]  = 1'b1;
                        ready_in[slot_addr]  = 1'b0;
                     end
                  end
                  OP_DELETE: begin
                     if (!slot_used) begin
                        pend_status_in = STATUS_NOT_FOUND;
                     end else begin
                        valid_in[slot_addr] = 1'b0;
                        ready_in[slot_addr] = 1'b0;
                     end
                  end
                  OP_SET_TIMING, OP_SET_RUNS: begin
                     if (table_empty) begin
                        pend_status_in = STATUS_EMPTY;
                     end else if (!slot_used) begin
                        pend_status_in = STATUS_NOT_FOUND;
                     end else if (req_chan.operation == OP_SET_TIMING) begin
                        prio_we   = 1'b1;
                        period_we = 1'b1;
                     end else begin
                        runs_we = 1'b1;
                     end
                  end
                  default: begin
                     // unused codes answer ok and change nothing
                  end
               endcase
            end
         end
         S_UPDATE: begin
            // write back each slot and mark the jobs issued on this tick
            if (data_valid_ff) begin
               ram_wr_addr           = data_idx_ff;
               cd_we                 = 1'b1;
               runs_we               = 1'b1;
               cd_wd                 = cd_new;
               runs_wd               = runs_new;
               ready_in[data_idx_ff] = verdict.ready;
               issue_in[data_idx_ff] = verdict.issue;
            end
            if (pass_done) begin
               state_in = S_SELECT;
               scan_in  = '0;
               best_in  = NO_PRIORITY;
            end
         end
         S_SELECT: begin
            // strict compare keeps the lowest slot among equal priorities
            if (data_valid_ff && verdict.take) begin
               best_in = {1'b0, prio_rd};
               pick_in = data_idx_ff;
            end
            if (pass_done) begin
               state_in       = S_EMIT;
               pend_status_in = STATUS_OK;
               if (best_ff != NO_PRIORITY) begin
                  pend_slot_in = 4'(pick_ff);
                  pend_ran_in  = 1'b1;
                  pend_last_in = (issue_left == '0);
                  issue_in     = issue_left;
               end else begin
                  // nothing due on this tick
                  pend_slot_in = 4'd0;
                  pend_ran_in  = 1'b0;
                  pend_last_in = 1'b1;
               end
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_slot_in   = pend_slot_ff;
               rsp_ran_in    = pend_ran_ff;
               rsp_last_in   = pend_last_ff;
               if (pend_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_SELECT;
                  scan_in  = '0;
                  best_in  = NO_PRIORITY;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         ready_ff      <= '0;
         issue_ff      <= '0;
         scan_ff       <= '0;
         data_valid_ff <= 1'b0;
         best_ff       <= NO_PRIORITY;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         ready_ff      <= ready_in;
         issue_ff      <= issue_in;
         scan_ff       <= scan_in;
         data_valid_ff <= data_valid_in;
         best_ff       <= best_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      data_idx_ff    <= data_idx_in;
      pick_ff        <= pick_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      pend_ran_ff    <= pend_ran_in;
      pend_last_ff   <= pend_last_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_ran_ff     <= rsp_ran_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // a ready job always belongs to a slot in the table
   `ASSERT_ALWAYS(a_ready_in_table, clock, reset, (ready_ff & ~valid_ff) == '0)
   // no issue marks are left over once the sequencer is idle
   `ASSERT_IMPLIES(a_idle_no_issue, clock, reset, state_ff == S_IDLE, issue_ff == '0)
   // a non-final transaction is never taken while the sequencer sits idle
   `ASSERT_IMPLIES(a_more_pending, clock, reset,
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.last, state_ff != S_IDLE)

endmodule
